// ----- hdl/per_source_window_rate_limiter_assert.svh -----
// Assertion macros shared by the rate limiter RTL.
`ifndef PER_SOURCE_WINDOW_RATE_LIMITER_ASSERT_SVH
`define PER_SOURCE_WINDOW_RATE_LIMITER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define PRSL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PRSL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PRSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/prsl_pkg.sv -----
// Package: table size, register indexes and the token type that moves along the cell chain.
`timescale 1ns / 1ps

package prsl_pkg;

  localparam int TABLE_ENTRIES = 64;

  localparam logic [31:0] RATE_LIMIT_RESET = 32'd1000;
  localparam logic [31:0] WINDOW_RESET     = 32'd1000000000;
  localparam logic [5:0]  PREFIX_RESET     = 6'd32;
  localparam logic [5:0]  PREFIX_MAX       = 6'd32;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_RATE_LIMIT = 2'd0,
    REG_WINDOW_LEN = 2'd1,
    REG_PREFIX_LEN = 2'd2
  } cfg_reg_t;

  // One packet on its way through the bucket cells.
  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic [63:0] now;
    logic        hit;      // a cell with this key was found
    logic [31:0] cnt;      // window count after update, valid with hit
    logic        created;  // a free cell took this key
  } tok_t;

endpackage

// ----- hdl/prsl_cell.sv -----
// One bucket cell: holds one table entry, updates it and passes the packet token on.
`timescale 1ns / 1ps
`include "per_source_window_rate_limiter_assert.svh"

module prsl_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [31:0]   win_len,
  input  prsl_pkg::tok_t tok_i,
  output prsl_pkg::tok_t tok_o
);
  import prsl_pkg::*;

  logic        valid_r;
  logic [31:0] key_r;
  logic [63:0] start_r;
  logic [31:0] count_r;
  tok_t        tok_r;

  logic        match;
  logic        claim;
  logic        restart;
  logic [63:0] elapsed;
  logic [31:0] inc;
  logic [31:0] count_nxt;
  logic [63:0] start_nxt;
  tok_t        tok_nxt;

  always_comb begin
    match   = tok_i.vld && valid_r && !tok_i.hit && !tok_i.created && (key_r == tok_i.key);
    claim   = tok_i.vld && !valid_r && !tok_i.hit && !tok_i.created;
    elapsed = tok_i.now - start_r;
    restart = (start_r == 64'd0) || (elapsed >= {32'd0, win_len});
    inc     = (count_r == COUNT_MAX) ? count_r : count_r + 32'd1;
    count_nxt = restart ? 32'd0 : inc;
    start_nxt = restart ? tok_i.now : start_r;

    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.cnt = count_nxt;
    end
    if (claim) begin
      tok_nxt.created = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv && claim) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && claim) begin
      key_r   <= tok_i.key;
      start_r <= tok_i.now;
      count_r <= 32'd0;
    end else if (adv && match) begin
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  `PRSL_ASSERT_NEXT(a_valid_sticky, clk, rst_n, valid_r, valid_r,
                    "bucket cell lost its entry")
  `PRSL_ASSERT_NEXT(a_claim_fills, clk, rst_n, adv && claim,
                    valid_r && (key_r == $past(tok_i.key)),
                    "claimed cell does not hold the key")
  `PRSL_ASSERT_IMPL(a_one_outcome, clk, rst_n, tok_r.vld, !(tok_r.hit && tok_r.created),
                    "token both matched and created a bucket")

endmodule

// ----- hdl/per_source_window_rate_limiter.sv -----
// Top level: configuration registers, key masking, bucket cell chain and result register.
// Each packet is masked to its key, then walks a chain of TABLE_ENTRIES bucket cells, one cell
// per cycle while the pipe is not held, and leaves through a result register; a new packet
// can enter every cycle unless a result waits on out_tready. A result is presented once its
// packet has passed the key masking register, every bucket cell and the result register.
// All stages advance together and hold while a result waits on out_tready.
// Packets see the table in arrival order, so a later packet always observes the buckets made or
// updated by earlier ones. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "per_source_window_rate_limiter_assert.svh"

module per_source_window_rate_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] source_address, [95:32] now_ns
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] verdict, [1] bucket_created, [2] table_full, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import prsl_pkg::*;

  logic [31:0] rate_limit_r;
  logic [31:0] window_len_r;
  logic [5:0]  prefix_len_r;

  logic        adv;
  logic [5:0]  prefix_eff;
  logic [31:0] key_mask;
  tok_t        front_nxt;
  tok_t        front_r;
  tok_t        chain [TABLE_ENTRIES+1];

  logic        out_tvalid_r;
  logic        verdict_r;
  logic        created_r;
  logic        full_r;
  logic        verdict_nxt;
  logic        created_nxt;
  logic        full_nxt;
  tok_t        last_tok;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r <= RATE_LIMIT_RESET;
      window_len_r <= WINDOW_RESET;
      prefix_len_r <= PREFIX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RATE_LIMIT: rate_limit_r <= cfg_data;
        REG_WINDOW_LEN: window_len_r <= cfg_data;
        REG_PREFIX_LEN: prefix_len_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // The whole pipe moves unless a result is waiting.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // Key masking stage
  always_comb begin
    prefix_eff = (prefix_len_r > PREFIX_MAX) ? PREFIX_MAX : prefix_len_r;
    key_mask   = ~(32'hFFFF_FFFF >> prefix_eff);
    front_nxt.vld     = in_tvalid;
    front_nxt.key     = in_tdata[31:0] & key_mask;
    front_nxt.now     = in_tdata[95:32];
    front_nxt.hit     = 1'b0;
    front_nxt.cnt     = 32'd0;
    front_nxt.created = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (adv) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  // Bucket cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    prsl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .win_len (window_len_r),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  // Result register
  always_comb begin
    last_tok    = chain[TABLE_ENTRIES];
    verdict_nxt = last_tok.hit && (last_tok.cnt >= rate_limit_r);
    created_nxt = last_tok.created;
    full_nxt    = !last_tok.hit && !last_tok.created;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= last_tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r <= verdict_nxt;
      created_r <= created_nxt;
      full_r    <= full_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, full_r, created_r, verdict_r};

  `PRSL_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, out_tvalid_r,
                    !(created_r && full_r) && !(verdict_r && (created_r || full_r)),
                    "result flags overlap")
  `PRSL_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_tvalid_r, in_tready,
                    "input stalled with no result waiting")
  `PRSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid_r && !out_tready,
                    out_tvalid_r && $stable(out_tdata),
                    "result changed while waiting")

endmodule
